// File: rtl/fmpd_pkg.sv
package fmpd_pkg;

   // sequencer states of the discriminator
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_PRE,
      ST_ITER,
      ST_DONE
   } state_type;

   // angle accumulator: unsigned, wraps, 2^31 stands for pi
   localparam int ANGLE_ACC_W = 32;
   localparam int ATAN_LEN    = 24;
   localparam int KIDX_W      = 5;

   localparam logic [ANGLE_ACC_W-1:0] Z_ZERO         = 32'h0000_0000;
   localparam logic [ANGLE_ACC_W-1:0] Z_HALF_PI      = 32'h4000_0000;
   localparam logic [ANGLE_ACC_W-1:0] Z_PI           = 32'h8000_0000;
   localparam logic [ANGLE_ACC_W-1:0] Z_NEG_HALF_PI  = 32'hC000_0000;

   // atan(2^-k), rounded to nearest, in accumulator units
   function automatic logic [ANGLE_ACC_W-1:0] atan_entry(input logic [KIDX_W-1:0] k);
      logic [ANGLE_ACC_W-1:0] v;
      case (k)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/fm_phase_discriminator_unit.sv
// fm quadrature discriminator: phase of previous sample times conjugate of current one
// the product is formed by four passes through the single multiplier, then N passes
//   (N = min(CORDIC_ITERS, 24)) through the shared shift-add rotation unit; the
//   rotation passes are skipped when the product vector lies on an axis
// a new input word is taken only after the previous result word is in the output register
// reset clears the sequencer, the output valid flag and the previous sample to zero
module fm_phase_discriminator_unit
   import fmpd_pkg::*;
#(
   parameter int SAMPLE_WIDTH = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_ITERS = 16
) (
   input  logic clock,
   input  logic reset,

   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // [SAMPLE_WIDTH-1:0] in_i, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] in_q, zero fill above
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]     req_tdata,

   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // [ANGLE_WIDTH-1:0] phase_step, zero fill above
   output logic [((ANGLE_WIDTH+7)/8)*8-1:0]        rsp_tdata
);

   localparam int RSP_TDW = ((ANGLE_WIDTH+7)/8)*8;
   // product vector width: 2*SW+1 exact, two more bits for cordic gain
   localparam int XW      = 2*SAMPLE_WIDTH+3;
   localparam int PW      = 2*SAMPLE_WIDTH;
   localparam int NITER   = (CORDIC_ITERS < ATAN_LEN) ? CORDIC_ITERS : ATAN_LEN;
   localparam logic [KIDX_W-1:0] K_LAST = KIDX_W'(NITER-1);
   localparam logic [ANGLE_ACC_W-1:0] Z_ROUND = ANGLE_ACC_W'(1) << (31-ANGLE_WIDTH);

   state_type state_ff, state_in;

   logic [1:0]                       mstep_ff, mstep_in;
   logic [KIDX_W-1:0]                k_ff, k_in;
   logic signed [SAMPLE_WIDTH-1:0]   cur_i_ff, cur_i_in;
   logic signed [SAMPLE_WIDTH-1:0]   cur_q_ff, cur_q_in;
   logic signed [SAMPLE_WIDTH-1:0]   prev_i_ff, prev_i_in;
   logic signed [SAMPLE_WIDTH-1:0]   prev_q_ff, prev_q_in;
   logic signed [XW-1:0]             x_ff, x_in;
   logic signed [XW-1:0]             y_ff, y_in;
   logic        [ANGLE_ACC_W-1:0]    z_ff, z_in;
   logic                             out_valid_ff, out_valid_in;
   logic        [ANGLE_WIDTH-1:0]    out_data_ff, out_data_in;

   // sequencer controls
   logic accept;
   logic mul_en;
   logic pre_en;
   logic iter_en;
   logic done_load;

   // shared multiplier
   logic signed [SAMPLE_WIDTH-1:0]   mul_a;
   logic signed [SAMPLE_WIDTH-1:0]   mul_b;
   logic signed [PW-1:0]             prod;
   logic signed [XW-1:0]             prod_x;

   // rotation unit
   logic signed [XW-1:0]             rot_x;
   logic signed [XW-1:0]             rot_y;
   logic        [ANGLE_ACC_W-1:0]    rot_z;

   logic                             on_axis;
   logic        [ANGLE_ACC_W-1:0]    z_rounded;

   // vector lies on an axis: angle is exact, no iterations needed
   assign on_axis = (x_ff == '0) || (y_ff == '0);

   // ------------------------------------------------------------------
   // next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_MUL;
         end
         ST_MUL: begin
            if (mstep_ff == 2'd3) state_in = ST_PRE;
         end
         ST_PRE: begin
            state_in = on_axis ? ST_DONE : ST_ITER;
         end
         ST_ITER: begin
            if (k_ff == K_LAST) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------
   // sequencer outputs
   // ------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      mul_en     = 1'b0;
      pre_en     = 1'b0;
      iter_en    = 1'b0;
      done_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_MUL:  mul_en     = 1'b1;
         ST_PRE:  pre_en     = 1'b1;
         ST_ITER: iter_en    = 1'b1;
         ST_DONE: done_load  = !out_valid_ff || rsp_tready;
         default: req_tready = 1'b0;
      endcase
   end

   assign accept = req_tvalid && req_tready;

   // ------------------------------------------------------------------
   // multiplier operand select: x = I*Ip + Q*Qp, y = I*Qp - Q*Ip
   // ------------------------------------------------------------------
   always_comb begin
      case (mstep_ff)
         2'd0: begin
            mul_a = cur_i_ff;
            mul_b = prev_i_ff;
         end
         2'd1: begin
            mul_a = cur_q_ff;
            mul_b = prev_q_ff;
         end
         2'd2: begin
            mul_a = cur_i_ff;
            mul_b = prev_q_ff;
         end
         default: begin
            mul_a = cur_q_ff;
            mul_b = prev_i_ff;
         end
      endcase
   end

   assign prod   = mul_a * mul_b;
   assign prod_x = XW'(prod);

   fmpd_cordic_rot #(
      .XW (XW)
   ) u_rot (
      .x      (x_ff),
      .y      (y_ff),
      .z      (z_ff),
      .k      (k_ff),
      .x_next (rot_x),
      .y_next (rot_y),
      .z_next (rot_z)
   );

   // round to ANGLE_WIDTH bits: add half an lsb, keep the top bits
   assign z_rounded = z_ff + Z_ROUND;

   // ------------------------------------------------------------------
   // datapath next values
   // ------------------------------------------------------------------
   always_comb begin
      mstep_in     = mstep_ff;
      k_in         = k_ff;
      cur_i_in     = cur_i_ff;
      cur_q_in     = cur_q_ff;
      prev_i_in    = prev_i_ff;
      prev_q_in    = prev_q_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      z_in         = z_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;

      if (rsp_tready) out_valid_in = 1'b0;

      if (accept) begin
         cur_i_in = req_tdata[SAMPLE_WIDTH-1:0];
         cur_q_in = req_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
         mstep_in = 2'd0;
      end

      if (mul_en) begin
         mstep_in = mstep_ff + 2'd1;
         case (mstep_ff)
            2'd0:    x_in = prod_x;
            2'd1:    x_in = x_ff + prod_x;
            2'd2:    y_in = prod_x;
            default: y_in = y_ff - prod_x;
         endcase
      end

      if (pre_en) begin
         // current sample becomes the previous one
         prev_i_in = cur_i_ff;
         prev_q_in = cur_q_ff;
         k_in      = '0;
         if (y_ff == '0) begin
            z_in = x_ff[XW-1] ? Z_PI : Z_ZERO;
         end else if (x_ff == '0) begin
            z_in = y_ff[XW-1] ? Z_NEG_HALF_PI : Z_HALF_PI;
         end else if (x_ff[XW-1]) begin
            // left half plane: quarter turn into the right half plane
            if (!y_ff[XW-1]) begin
               x_in = y_ff;
               y_in = -x_ff;
               z_in = Z_HALF_PI;
            end else begin
               x_in = -y_ff;
               y_in = x_ff;
               z_in = Z_NEG_HALF_PI;
            end
         end else begin
            z_in = Z_ZERO;
         end
      end

      if (iter_en) begin
         x_in = rot_x;
         y_in = rot_y;
         z_in = rot_z;
         k_in = k_ff + KIDX_W'(1);
      end

      if (done_load) begin
         out_valid_in = 1'b1;
         out_data_in  = z_rounded[ANGLE_ACC_W-1 -: ANGLE_WIDTH];
      end
   end

   // ------------------------------------------------------------------
   // registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mstep_ff     <= '0;
         k_ff         <= '0;
         prev_i_ff    <= '0;
         prev_q_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mstep_ff     <= mstep_in;
         k_ff         <= k_in;
         prev_i_ff    <= prev_i_in;
         prev_q_ff    <= prev_q_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      cur_i_ff    <= cur_i_in;
      cur_q_ff    <= cur_q_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      z_ff        <= z_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_TDW'(out_data_ff);

endmodule

// File: rtl/fmpd_cordic_rot.sv
module fmpd_cordic_rot
   import fmpd_pkg::*;
#(
   parameter int XW = 35
) (
   input  logic signed [XW-1:0]          x,
   input  logic signed [XW-1:0]          y,
   input  logic        [ANGLE_ACC_W-1:0] z,
   input  logic        [KIDX_W-1:0]      k,
   output logic signed [XW-1:0]          x_next,
   output logic signed [XW-1:0]          y_next,
   output logic        [ANGLE_ACC_W-1:0] z_next
);

   logic signed [XW-1:0]          xs;
   logic signed [XW-1:0]          ys;
   logic        [ANGLE_ACC_W-1:0] step;

   // shared barrel shifters, floor shift
   assign xs   = x >>> k;
   assign ys   = y >>> k;
   assign step = atan_entry(k);

   // rotate toward the positive real axis
   always_comb begin
      if (!y[XW-1]) begin
         x_next = x + ys;
         y_next = y - xs;
         z_next = z + step;
      end else begin
         x_next = x - ys;
         y_next = y + xs;
         z_next = z - step;
      end
   end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int SAMPLE_W   = 16;
   localparam int ANGLE_W    = 16;
   localparam int ITERS      = 16;
   // the rotation unit never runs more steps than it has arctangent entries
   localparam int ROT_STEPS  = (ITERS < 24) ? ITERS : 24;
   localparam int LATENCY    = ROT_STEPS + 6;
   localparam int N_RANDOM   = 1400;
   localparam int HOLD_CYCLES = 400;

   // angle accumulator codes, 2^31 stands for pi
   localparam logic [31:0] ACC_ZERO     = 32'h0000_0000;
   localparam logic [31:0] ACC_HALF_PI  = 32'h4000_0000;
   localparam logic [31:0] ACC_PI       = 32'h8000_0000;
   localparam logic [31:0] ACC_NEG_HALF = 32'hC000_0000;

   // one pending entry: a complex sample, or a marker that makes the sender
   // wait until every expected phase step has come back
   typedef struct {
      logic signed [SAMPLE_W-1:0] i;
      logic signed [SAMPLE_W-1:0] q;
      bit                         drain;
   } sample_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // [15:0] in_i, [31:16] in_q
   logic [31:0]           req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [15:0] phase_step
   logic [15:0]           rsp_tdata;

   // atan(2^-k) rounded to nearest in accumulator units
   logic [31:0] atan_step [0:23] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
      32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
      32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   sample_entry_type pending_samples[$];
   logic [15:0]      expected_steps[$];
   int               mismatch_count = 0;

   // sender-side state
   logic signed [15:0] last_i = '0;
   logic signed [15:0] last_q = '0;
   logic signed [15:0] offered_i = '0;
   logic signed [15:0] offered_q = '0;
   int                 send_gap = 0;
   int                 words_sent = 0;
   bit                 send_offer;
   sample_entry_type   next_entry;

   // receiver-side state
   int                 recv_stall = 0;
   int                 recv_hold = 0;
   int                 words_seen = 0;
   bit                 recv_ready;
   logic [15:0]        want_step;

   fm_phase_discriminator_unit #(
      .SAMPLE_WIDTH (SAMPLE_W),
      .ANGLE_WIDTH  (ANGLE_W),
      .CORDIC_ITERS (ITERS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   // phase of prev * conj(cur), rounded to ANGLE_W bits, pi wraps to the most
   // negative code
   function automatic logic [15:0] phase_step_of(input logic signed [15:0] pre_i,
                                                 input logic signed [15:0] pre_q,
                                                 input logic signed [15:0] cur_i,
                                                 input logic signed [15:0] cur_q);
      longint      x;
      longint      y;
      longint      t;
      longint      xs;
      longint      ys;
      logic [31:0] z;
      x = longint'(cur_i) * longint'(pre_i) + longint'(cur_q) * longint'(pre_q);
      y = longint'(cur_i) * longint'(pre_q) - longint'(cur_q) * longint'(pre_i);
      z = ACC_ZERO;
      if (y == 0) begin
         // real axis, and the zero vector
         z = (x < 0) ? ACC_PI : ACC_ZERO;
      end else if (x == 0) begin
         z = (y > 0) ? ACC_HALF_PI : ACC_NEG_HALF;
      end else begin
         // fold the left half plane over by a quarter turn
         if (x < 0) begin
            t = x;
            if (y >= 0) begin
               x = y;
               y = -t;
               z = ACC_HALF_PI;
            end else begin
               x = -y;
               y = t;
               z = ACC_NEG_HALF;
            end
         end
         for (int k = 0; k < ROT_STEPS; k++) begin
            xs = x >>> k;
            ys = y >>> k;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + atan_step[k];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - atan_step[k];
            end
         end
      end
      z = z + (32'd1 << (31 - ANGLE_W));
      return z[31 -: ANGLE_W];
   endfunction

   // idle lengths: mostly none or short, now and then long; quiet stretches have none
   function automatic int idle_length(input bit quiet);
      int r;
      if (quiet)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 4);
      else
         return $urandom_range(10, 60);
   endfunction

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %0d expected %0d (result word %0d)",
               $realtime, what, $signed(got), $signed(want), words_seen);
   endtask

   task automatic add_sample(input int si, input int sq);
      sample_entry_type e;
      e.i = si[15:0];
      e.q = sq[15:0];
      e.drain = 1'b0;
      pending_samples = {pending_samples, e};
   endtask

   task automatic add_drain();
      sample_entry_type e;
      e.i = '0;
      e.q = '0;
      e.drain = 1'b1;
      pending_samples = {pending_samples, e};
   endtask

   // sender: offers the pending samples, predicts each accepted word
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         last_i = '0;
         last_q = '0;
      end else begin
         send_offer = req_tvalid;
         if (req_tvalid && req_tready) begin
            expected_steps = {expected_steps,
                              phase_step_of(last_i, last_q, offered_i, offered_q)};
            last_i = offered_i;
            last_q = offered_q;
            words_sent++;
            send_offer = 1'b0;
            // every fourth block of 150 words goes without gaps
            send_gap = idle_length(((words_sent / 150) % 4) == 3);
         end
         if (!send_offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_samples.size() > 0 && pending_samples[0].drain) begin
               // hold back until the block has returned everything
               if (expected_steps.size() == 0)
                  void'(pending_samples.pop_front());
            end else if (pending_samples.size() > 0) begin
               next_entry = pending_samples.pop_front();
               offered_i = next_entry.i;
               offered_q = next_entry.q;
               req_tdata <= {next_entry.q, next_entry.i};
               send_offer = 1'b1;
            end
         end
         req_tvalid <= send_offer;
      end
   end

   // receiver: checks each result word against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            words_seen++;
            if (expected_steps.size() == 0) begin
               report_mismatch("unexpected word", rsp_tdata, '0);
            end else begin
               want_step = expected_steps.pop_front();
               if (rsp_tdata !== want_step)
                  report_mismatch("phase_step", rsp_tdata, want_step);
            end
            recv_stall = idle_length(((words_seen / 130) % 4) == 1);
            // long back-pressure so the block fills and stalls its input
            if (words_seen == 250 || words_seen == 800)
               recv_hold = HOLD_CYCLES;
         end
         if (recv_hold > 0) begin
            recv_hold--;
            recv_ready = 1'b0;
         end else if (recv_stall > 0) begin
            recv_stall--;
            recv_ready = 1'b0;
         end else begin
            recv_ready = 1'b1;
         end
         rsp_tready <= recv_ready;
      end
   end

   // stimulus and end of run
   initial begin
      int    seg_len;
      int    mode;
      int    amp;
      int    v_i;
      int    v_q;
      int    corner [5];
      real   ph;
      real   dph;

      corner = '{-32768, -1, 0, 1, 32767};

      // zero vector right after reset, then again with a zero previous sample
      add_sample(0, 0);
      add_sample(32767, 0);
      // positive real axis, then negative real axis
      add_sample(32767, 0);
      add_sample(-32768, 0);
      // imaginary axis, positive
      add_sample(0, 32767);
      // imaginary axis, negative
      add_sample(-32768, 0);
      // corners of the sample range
      add_sample(32767, 32767);
      add_sample(-32768, -32768);
      add_sample(-32768, 32767);
      add_sample(32767, -32768);
      add_sample(-1, -1);
      add_sample(1, 1);
      add_sample(1, -1);
      // left half plane, both signs of the imaginary part
      add_sample(100, 0);
      add_sample(-100, -5);
      add_sample(100, 0);
      add_sample(-100, 5);
      // small steps near zero angle
      add_sample(30000, 1);
      add_sample(30000, -1);
      add_sample(0, 0);
      add_sample(-1, 0);
      add_sample(12345, -23456);
      add_drain();

      while (pending_samples.size() < N_RANDOM + 40) begin
         seg_len = $urandom_range(20, 120);
         mode = $urandom_range(0, 9);
         amp = $urandom_range(1, 32767);
         ph = $urandom_range(0, 6283) / 1000.0;
         dph = ($urandom_range(0, 2000) - 1000.0) / 1000.0 * 3.14159265;
         if ($urandom_range(0, 1))
            dph = dph / 64.0;
         for (int n = 0; n < seg_len; n++) begin
            case (mode)
               0, 1, 2, 3, 4: begin
                  // fm-like phasor: steady amplitude, steady phase advance
                  ph = ph + dph;
                  v_i = $rtoi(amp * $cos(ph));
                  v_q = $rtoi(amp * $sin(ph));
               end
               5, 6: begin
                  v_i = $urandom_range(0, 65535) - 32768;
                  v_q = $urandom_range(0, 65535) - 32768;
               end
               7: begin
                  // tiny values hit the axes and the zero vector often
                  v_i = $urandom_range(0, 8) - 4;
                  v_q = $urandom_range(0, 8) - 4;
               end
               8: begin
                  // repeats and sign flips of one sample
                  if (n == 0 || $urandom_range(0, 3) == 0) begin
                     v_i = $urandom_range(0, 65535) - 32768;
                     v_q = $urandom_range(0, 65535) - 32768;
                  end else if ($urandom_range(0, 1)) begin
                     v_i = -v_i;
                     v_q = -v_q;
                  end
               end
               default: begin
                  v_i = corner[$urandom_range(0, 4)];
                  v_q = corner[$urandom_range(0, 4)];
               end
            endcase
            add_sample(v_i, v_q);
         end
         // one pause mid-run until every result is back
         if (pending_samples.size() > 700 && pending_samples.size() < 700 + seg_len + 1)
            add_drain();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_samples.size() > 0 || req_tvalid || expected_steps.size() > 0)
         @(posedge clock);
      repeat (2 * LATENCY + 10) @(posedge clock);

      if (mismatch_count == 0 && expected_steps.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // timeout
   initial begin
      #20_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule
